@@ sv/b64e_pkg.sv @@
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the alphabet lookup for the base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned GROUP_W = 6;
  localparam int unsigned MAX_CHARS = 4;
  localparam int unsigned IDX_W = 2;

  // pending bit counts that the encoder can hold
  localparam logic [2:0] CNT_ZERO = 3'd0;
  localparam logic [2:0] CNT_TWO  = 3'd2;
  localparam logic [2:0] CNT_FOUR = 3'd4;

  localparam logic [CHAR_W-1:0] PAD_CHAR = 7'd61;

  // permuted alphabet, first character in the top byte
  localparam logic [511:0] ALPHABET =
    "lksOm9BteESFLuDaNiUho1dwnRG0yc+jAKpXgYrH6xIQPW4vM7q32TbfZC8/5VJz";

  // one encoded request: up to four characters, index of the last one,
  // and whether it closes the message
  typedef struct packed {
    logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
    logic [IDX_W-1:0]                 last_idx;
    logic                             fin;
  } bundle_t;

  function automatic logic [CHAR_W-1:0] b64e_char(input logic [GROUP_W-1:0] grp);
    logic [8:0] off;
    off = {~grp, 3'b000};
    return ALPHABET[off +: CHAR_W];
  endfunction

endpackage

@@ sv/b64e_encode.sv @@
// ----------------------------------------------------------------------------
// b64e_encode
// Pending-bit state and the single-pass expansion of one byte to characters.
// ----------------------------------------------------------------------------
module b64e_encode
  import b64e_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  input  logic       advance,
  output bundle_t    bundle
);

  logic [3:0] bits_r, bits_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  always_comb begin
    bundle.chars    = {MAX_CHARS{PAD_CHAR}};
    bundle.last_idx = '0;
    bundle.fin      = final_byte;
    bits_nxt        = bits_r;
    cnt_nxt         = cnt_r;
    case (cnt_r)
      CNT_TWO: begin
        bundle.chars[0] = b64e_char({bits_r[1:0], data_byte[7:4]});
        if (final_byte) begin
          bundle.chars[1] = b64e_char({data_byte[3:0], 2'b00});
          bundle.last_idx = 2'd2;
        end else begin
          bundle.last_idx = 2'd0;
        end
        bits_nxt = data_byte[3:0];
        cnt_nxt  = CNT_FOUR;
      end
      CNT_FOUR: begin
        bundle.chars[0] = b64e_char({bits_r[3:0], data_byte[7:6]});
        bundle.chars[1] = b64e_char(data_byte[5:0]);
        bundle.last_idx = 2'd1;
        bits_nxt = 4'd0;
        cnt_nxt  = CNT_ZERO;
      end
      default: begin
        bundle.chars[0] = b64e_char(data_byte[7:2]);
        if (final_byte) begin
          bundle.chars[1] = b64e_char({data_byte[1:0], 4'b0000});
          bundle.last_idx = 2'd3;
        end else begin
          bundle.last_idx = 2'd0;
        end
        bits_nxt = {2'b00, data_byte[1:0]};
        cnt_nxt  = CNT_TWO;
      end
    endcase
    if (final_byte) begin
      bits_nxt = 4'd0;
      cnt_nxt  = CNT_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= 4'd0;
      cnt_r  <= CNT_ZERO;
    end else if (advance) begin
      bits_r <= bits_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  a_cnt_legal: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CNT_ZERO || cnt_r == CNT_TWO || cnt_r == CNT_FOUR)
    else $error("pending count out of range");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && final_byte |=> cnt_r == CNT_ZERO)
    else $error("state not cleared after last byte");

endmodule

@@ sv/b64e_serial.sv @@
// ----------------------------------------------------------------------------
// b64e_serial
// Result register: holds one encoded request, hands out a character a cycle unless stalled.
// ----------------------------------------------------------------------------
module b64e_serial
  import b64e_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  bundle_t           bundle,
  input  logic              load,
  output logic              free,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_end_of_text
);

  logic                             valid_r;
  logic [MAX_CHARS-1:0][CHAR_W-1:0] chars_r;
  logic [IDX_W-1:0]                 last_r;
  logic [IDX_W-1:0]                 idx_r;
  logic                             fin_r;
  logic                             take;
  logic                             done;

  assign take = valid_r && !out_stall;
  assign done = take && (idx_r == last_r);
  assign free = !valid_r || done;

  assign out_valid       = valid_r;
  assign out_char        = chars_r[idx_r];
  assign out_end_of_text = fin_r && (idx_r == last_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (done) begin
      valid_r <= 1'b0;
    end else if (take) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chars_r <= bundle.chars;
      last_r  <= bundle.last_idx;
      fin_r   <= bundle.fin;
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> idx_r <= last_r)
    else $error("character index past end of request");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("request loaded over unfinished one");

endmodule

@@ sv/base64_encoder_custom_alphabet_unit.sv @@
// ----------------------------------------------------------------------------
// base64_encoder_custom_alphabet_unit
// Byte-in, character-out base64 encoder with a fixed permuted alphabet.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one message byte per request, with
//   in_final_byte high on the last byte of a message.
//   Output channel (out_valid / out_stall): one 7-bit ASCII character per
//   request; out_end_of_text marks the last character of a message.
//   A byte yields one or two characters; the last byte yields two to four
//   (trailing zero-padded group and '=' padding as needed).
// Path: an accepted byte is held in the input register, encoded, and moved
//   into the result register once that is free, which presents its characters.
// Throughput: one character per cycle on the output while out_stall is low; a
//   byte is accepted every cycle the input register is empty or can hand its
//   request to the result register, so the byte rate is set by the number of
//   characters each byte produces through the single output port.
// Reset: clears both registers' valid flags and the pending bits, so the
//   first byte after reset starts a new message.
// Stall: when out_stall is high the current character holds; the input
//   register still takes one more byte if it is empty, then in_stall rises
//   until the result register drains.
// ----------------------------------------------------------------------------
module base64_encoder_custom_alphabet_unit
  import b64e_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_data_byte,
  input  logic              in_final_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_end_of_text
);

  // input register
  logic       in_v_r;
  logic [7:0] data_r;
  logic       final_r;

  logic       free;
  logic       move;
  logic       accept;
  bundle_t    bundle;

  // advance the held byte into the result register once it is free
  assign move     = in_v_r && free;
  assign in_stall = in_v_r && !move;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (accept) begin
      in_v_r <= 1'b1;
    end else if (move) begin
      in_v_r <= 1'b0;
    end
  end

  // payload: hold while waiting, capture on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      data_r  <= in_data_byte;
      final_r <= in_final_byte;
    end
  end

  b64e_encode u_encode (
    .clk        (clk),
    .rst_n      (rst_n),
    .data_byte  (data_r),
    .final_byte (final_r),
    .advance    (move),
    .bundle     (bundle)
  );

  b64e_serial u_serial (
    .clk             (clk),
    .rst_n           (rst_n),
    .bundle          (bundle),
    .load            (move),
    .free            (free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char        (out_char),
    .out_end_of_text (out_end_of_text)
  );

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_v_r && out_valid)
    else $error("input stalled with room to move");

  a_move_shows: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> out_valid)
    else $error("moved request not presented");

endmodule
